// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the pattern matcher.
// Include by bare file name; each use stands on its own line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rstn, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

// File: src/wpm_pkg.sv
// Package for the wildcard pattern matcher: command codes, control state,
// wildcard byte constants and the cell control/status structs. No dependencies.
package wpm_pkg;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  typedef enum logic [1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_TEXT    = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SWEEP  = 2'd1,
    ST_REPORT = 2'd2
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic       append;     // write the broadcast byte into the cell at the fill point
    logic       restart;    // reload the column bit from the star prefix bit
    logic [7:0] char_byte;  // pattern byte on append, text byte during a sweep
  } cell_ctrl_t;

  // Status from each cell back to the controller.
  typedef struct packed {
    logic tail_match;  // column bit of the last pattern position
    logic sweep_done;  // sweep token reached the last pattern position
  } cell_stat_t;

endpackage

// File: src/wpm_if.sv
// Valid/ready channel interfaces of the wildcard pattern matcher.
// Input channel carries command and byte; output channel carries the result.
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_byte;

  modport source (output valid, output func, output char_byte, input ready);
  modport sink   (input valid, input func, input char_byte, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_full;

  modport source (output valid, output matched, output pattern_full, input ready);
  modport sink   (input valid, input matched, input pattern_full, output ready);
endinterface

// File: src/wpm_cell.sv
// One pattern position: stored byte, star prefix bit and match column bit.
// Depends on wpm_pkg; chained by the top level, token passed left to right.
module wpm_cell import wpm_pkg::*; #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned LenW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [LenW-1:0] len_i,
  input  logic            tok_i,
  input  logic            diag_i,
  input  logic            below_i,
  input  logic            star_i,
  output logic            tok_o,
  output logic            diag_o,
  output logic            below_o,
  output logic            star_o,
  output cell_stat_t      stat_o
);

  logic [7:0] pat_byte_q, pat_byte_d;
  logic       star_q, star_d;
  logic       col_q, col_d;
  logic       tok_q, tok_d;
  logic       diag_q, below_q;
  logic       wr_here;
  logic       is_last;
  logic       new_col;

  assign wr_here = ctrl_i.append && (len_i == LenW'(Idx));
  assign is_last = (len_i == LenW'(Idx + 1));

  always_comb begin
    if (pat_byte_q == STAR_BYTE) begin
      new_col = below_i | col_q;
    end else if (pat_byte_q == ANY_BYTE || pat_byte_q == ctrl_i.char_byte) begin
      new_col = diag_i;
    end else begin
      new_col = 1'b0;
    end
  end

  always_comb begin
    pat_byte_d = wr_here ? ctrl_i.char_byte : pat_byte_q;
    star_d     = wr_here ? (star_i && (ctrl_i.char_byte == STAR_BYTE)) : star_q;
    priority if (ctrl_i.restart) begin
      col_d = star_d;
    end else if (tok_i) begin
      col_d = new_col;
    end else begin
      col_d = col_q;
    end
    // stop the token at the last pattern position
    tok_d = tok_i && !is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      star_q <= 1'b0;
      col_q  <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      star_q <= star_d;
      col_q  <= col_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_byte_q <= pat_byte_d;
    if (tok_i) begin
      diag_q  <= col_q;
      below_q <= new_col;
    end
  end

  assign tok_o             = tok_q;
  assign diag_o            = diag_q;
  assign below_o           = below_q;
  assign star_o            = star_q;
  assign stat_o.tail_match = col_q && is_last;
  assign stat_o.sweep_done = tok_i && is_last;

endmodule

// File: src/wildcard_pattern_matcher.sv
// Wildcard pattern matcher: '?' matches any one byte, '*' any run. Pattern
// bytes are appended with func 0 (each append that fits restarts the text),
// text bytes with func 1, func 2 restarts the text and func 3 clears the
// pattern. Every item yields one result. Append, restart and clear go from
// accept to the report state; a text byte on a non-empty pattern first sends
// a token along the cell chain one pattern position per cycle. One item is
// in flight at a time; a waiting result sits in the output register.
// Depends on wpm_pkg, wpm_if, wpm_cell and assert_macros.svh.
`include "assert_macros.svh"

module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wpm_in_if.sink     in_i,
  wpm_out_if.source  out_o
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic            text_empty_q, text_empty_d;
  logic            start_q, start_d;
  logic            diag0_q;
  logic [7:0]      char_q;
  logic            full_q, full_d;
  logic            out_valid_q, out_valid_d;
  logic            matched_q, out_full_q;

  func_e           func;
  logic            accept;
  logic            is_full;
  logic            app_ok;
  logic            out_free;
  logic            load_out;
  logic            matched_d;
  logic            sweep_done;
  logic            tail_match;
  cell_ctrl_t      ctrl;

  logic [PATTERN_MAX:0]   tok_w, diag_w, below_w, star_w;
  cell_stat_t             stat_w [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] done_v, match_v;

  assign func     = func_e'(in_i.func);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_i.ready;
  assign is_full  = (len_q == LenW'(PATTERN_MAX));
  assign app_ok   = accept && (func == FUNC_APPEND) && !is_full;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    ctrl.append    = app_ok;
    ctrl.restart   = app_ok || (accept && (func == FUNC_RESTART || func == FUNC_CLEAR));
    ctrl.char_byte = (state_q == ST_IDLE) ? in_i.char_byte : char_q;
  end

  assign tok_w[0]   = start_q;
  assign diag_w[0]  = diag0_q;
  assign below_w[0] = 1'b0;
  assign star_w[0]  = 1'b1;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    wpm_cell #(
      .Idx  (k),
      .LenW (LenW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .len_i   (len_q),
      .tok_i   (tok_w[k]),
      .diag_i  (diag_w[k]),
      .below_i (below_w[k]),
      .star_i  (star_w[k]),
      .tok_o   (tok_w[k+1]),
      .diag_o  (diag_w[k+1]),
      .below_o (below_w[k+1]),
      .star_o  (star_w[k+1]),
      .stat_o  (stat_w[k])
    );
    assign done_v[k]  = stat_w[k].sweep_done;
    assign match_v[k] = stat_w[k].tail_match;
  end

  assign sweep_done = |done_v;
  assign tail_match = |match_v;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (func == FUNC_TEXT && len_q != '0) ? ST_SWEEP : ST_REPORT;
        end
      end
      ST_SWEEP: begin
        if (sweep_done) state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    len_d        = len_q;
    text_empty_d = text_empty_q;
    start_d      = 1'b0;
    full_d       = full_q;
    if (accept) begin
      full_d = (func == FUNC_APPEND) && is_full;
      unique case (func)
        FUNC_APPEND: begin
          if (!is_full) begin
            len_d        = len_q + LenW'(1);
            text_empty_d = 1'b1;
          end
        end
        FUNC_TEXT: begin
          text_empty_d = 1'b0;
          start_d      = (len_q != '0);
        end
        FUNC_RESTART: text_empty_d = 1'b1;
        FUNC_CLEAR: begin
          len_d        = '0;
          text_empty_d = 1'b1;
        end
        default: ;
      endcase
    end
    load_out    = (state_q == ST_REPORT) && out_free;
    matched_d   = (len_q == '0) ? text_empty_q : tail_match;
    out_valid_d = (out_valid_q && !out_o.ready) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      len_q        <= '0;
      text_empty_q <= 1'b1;
      start_q      <= 1'b0;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      text_empty_q <= text_empty_d;
      start_q      <= start_d;
      full_q       <= full_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diag0_q <= text_empty_q;
      char_q  <= in_i.char_byte;
    end
    if (load_out) begin
      matched_q  <= matched_d;
      out_full_q <= full_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.matched      = matched_q;
  assign out_o.pattern_full = out_full_q;

  `ASSERT_CLK(a_one_token, clk_i, rst_ni, $onehot0(tok_w), "more than one sweep token")
  `ASSERT_NEVER(a_ready_in_sweep, clk_i, rst_ni, in_i.ready && (|tok_w), "ready during a sweep")
  `ASSERT_NEVER(a_len_range, clk_i, rst_ni, len_q > LenW'(PATTERN_MAX), "pattern length overflow")
  `ASSERT_CLK(a_full_flag, clk_i, rst_ni, (accept && func == FUNC_APPEND && is_full) |=> (full_q && state_q == ST_REPORT && $stable(len_q)), "dropped append not flagged")

endmodule
